>>> rtl/core/oaht_pkg.sv
`timescale 1ns / 1ps
// Package for the open-addressing hash table: operation, slot status,
// probe mode and register index codes, plus field widths. No dependencies.
package oaht_pkg;

    localparam int OAHT_DEPTH_DEFAULT = 1024;

    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int HASH_W = 32;
    localparam int SIZE_W = 11;
    localparam int COEF_W = 10;
    localparam int OP_W   = 2;
    localparam int MODE_W = 2;
    localparam int CIDX_W = 2;
    localparam int RES_W  = 48;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    localparam logic [1:0] SLOT_EMPTY    = 2'd0;
    localparam logic [1:0] SLOT_OCCUPIED = 2'd1;
    localparam logic [1:0] SLOT_DELETED  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUAD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_PROBE_MODE = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_QUAD_C1    = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_QUAD_C2    = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_TABLE_SIZE = 2'd3;

    // Result word bit positions.
    localparam int RES_SUCCESS = 0;
    localparam int RES_FOUND_LO = 1;
    localparam int RES_OCC_LO = 33;
    localparam int RES_EMPTY = 44;
    localparam int RES_FULL = 45;

endpackage

>>> rtl/core/oaht_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/open_addressing_hash_table.sv
`timescale 1ns / 1ps
// Open-addressing hash table top level: sequencer, shared remainder unit and
// slot memories. Depends on oaht_pkg and oaht_ram.
//
// Channel   Direction  Signals                              Contents
// s_*       in         s_tvalid s_tready s_tdata s_tuser    request
// m_*       out        m_tvalid m_tready m_tdata            result
// cfg_*     in         cfg_valid cfg_ready cfg_addr cfg_data register write
//
// A request reduces its home hash modulo the table size; quadratic probing then reduces c1 + c2
// and 2*c2, double hashing the step hash; a valid operation makes 1 to table-size probes.
// The bit-serial remainder unit reduces one bit per cycle.
// After reset a clearing pass empties the status memory.
// A result that is not taken holds the block before it writes the next one.
module open_addressing_hash_table
    import oaht_pkg::*;
#(
    parameter int TABLE_DEPTH = OAHT_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [127:0]        s_tdata,   // key, item_value, home_hash, step_hash
    input  logic [OP_W-1:0]     s_tuser,   // op
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [RES_W-1:0]    m_tdata,   // success, found_value, occupancy,
                                           // table_empty, table_full, zero pad
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CIDX_W-1:0]   cfg_addr,
    input  logic [SIZE_W-1:0]   cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RED   = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [MODE_W-1:0]   mode_reg;
    logic [COEF_W-1:0]   c1_reg, c2_reg;
    logic [SIZE_W-1:0]   tsize_reg;
    logic [AW-1:0]       clr_reg, clr_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [VAL_W-1:0]    val_reg, val_next;
    logic [HASH_W-1:0]   step_reg, step_next;
    logic [HASH_W-1:0]   div_reg, div_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic [1:0]          sel_reg, sel_next;
    logic [SIZE_W-1:0]   rem_reg, rem_next;
    logic [SIZE_W-1:0]   idx_reg, idx_next;
    logic [SIZE_W-1:0]   delta_reg, delta_next;
    logic [SIZE_W-1:0]   dd_reg, dd_next;
    logic [SIZE_W-1:0]   pcnt_reg, pcnt_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                ok_reg, ok_next;
    logic [VAL_W-1:0]    found_reg, found_next;
    logic                mvalid_reg, mvalid_next;
    logic [RES_W-1:0]    mdata_reg, mdata_next;

    logic [SIZE_W-1:0]   size;
    logic [SIZE_W:0]     rem_t;
    logic [SIZE_W-1:0]   rem_step;
    logic [SIZE_W:0]     idx_sum, delta_sum;
    logic [SIZE_W-1:0]   idx_adv, delta_adv;
    logic [SIZE_W-1:0]   c_sum, c2_dbl;
    logic                last_probe;

    logic                st_we;
    logic [AW-1:0]       st_waddr;
    logic [1:0]          st_wdata, st_rdata;
    logic                kv_we;
    logic [KEY_W+VAL_W-1:0] kv_rdata;
    logic [AW-1:0]       raddr;

    assign size = (tsize_reg == '0) ? SIZE_W'(1)
                : ({21'd0, tsize_reg} > 32'(TABLE_DEPTH)) ? SIZE_W'(TABLE_DEPTH)
                : tsize_reg;

    assign rem_t    = {rem_reg, div_reg[HASH_W-1]};
    assign rem_step = (rem_t >= {1'b0, size}) ? SIZE_W'(rem_t - {1'b0, size})
                                               : rem_t[SIZE_W-1:0];

    assign idx_sum   = {1'b0, idx_reg} + {1'b0, delta_reg};
    assign idx_adv   = (idx_sum >= {1'b0, size}) ? SIZE_W'(idx_sum - {1'b0, size})
                                                 : idx_sum[SIZE_W-1:0];
    assign delta_sum = {1'b0, delta_reg} + {1'b0, dd_reg};
    assign delta_adv = (delta_sum >= {1'b0, size}) ? SIZE_W'(delta_sum - {1'b0, size})
                                                   : delta_sum[SIZE_W-1:0];

    assign c_sum      = {1'b0, c1_reg} + {1'b0, c2_reg};
    assign c2_dbl     = {c2_reg, 1'b0};
    assign last_probe = (({1'b0, pcnt_reg} + 12'd1) == {1'b0, size});
    assign raddr      = AW'(idx_reg);

    oaht_ram #(.WIDTH(2), .DEPTH(TABLE_DEPTH)) u_status (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (raddr),
        .rdata (st_rdata)
    );

    oaht_ram #(.WIDTH(KEY_W + VAL_W), .DEPTH(TABLE_DEPTH)) u_entry (
        .clk   (clk),
        .we    (kv_we),
        .waddr (raddr),
        .wdata ({val_reg, key_reg}),
        .raddr (raddr),
        .rdata (kv_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        step_next   = step_reg;
        div_next    = div_reg;
        cnt_next    = cnt_reg;
        sel_next    = sel_reg;
        rem_next    = rem_reg;
        idx_next    = idx_reg;
        delta_next  = delta_reg;
        dd_next     = dd_reg;
        pcnt_next   = pcnt_reg;
        count_next  = count_reg;
        ok_next     = ok_reg;
        found_next  = found_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mdata_next  = mdata_reg;
        st_we       = 1'b0;
        st_waddr    = raddr;
        st_wdata    = SLOT_OCCUPIED;
        kv_we       = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                st_we    = 1'b1;
                st_waddr = clr_reg;
                st_wdata = SLOT_EMPTY;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(TABLE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tuser;
                    key_next   = s_tdata[31:0];
                    val_next   = s_tdata[63:32];
                    div_next   = s_tdata[95:64];
                    step_next  = s_tdata[127:96];
                    cnt_next   = 6'd32;
                    sel_next   = 2'd0;
                    rem_next   = '0;
                    ok_next    = 1'b0;
                    found_next = '0;
                    state_next = (s_tuser == OP_INSERT || s_tuser == OP_DELETE
                                  || s_tuser == OP_LOOKUP) ? S_RED : S_OUT;
                end
            end
            S_RED:
            begin
                rem_next = rem_step;
                div_next = {div_reg[HASH_W-2:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    rem_next = '0;
                    case (sel_reg)
                        2'd0:
                        begin
                            idx_next  = rem_step;
                            pcnt_next = '0;
                            sel_next  = 2'd1;
                            if (mode_reg == MODE_QUAD)
                            begin
                                div_next = {c_sum, 21'd0};
                                cnt_next = 6'(SIZE_W);
                            end
                            else if (mode_reg == MODE_DOUBLE)
                            begin
                                div_next = step_reg;
                                cnt_next = 6'd32;
                            end
                            else
                            begin
                                delta_next = (size == SIZE_W'(1)) ? '0 : SIZE_W'(1);
                                dd_next    = '0;
                                state_next = S_RD;
                            end
                        end
                        2'd1:
                        begin
                            delta_next = rem_step;
                            dd_next    = '0;
                            if (mode_reg == MODE_QUAD)
                            begin
                                div_next = {c2_dbl, 21'd0};
                                cnt_next = 6'(SIZE_W);
                                sel_next = 2'd2;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            dd_next    = rem_step;
                            state_next = S_RD;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                state_next = S_RD;
                idx_next   = idx_adv;
                delta_next = delta_adv;
                pcnt_next  = pcnt_reg + SIZE_W'(1);
                if (op_reg == OP_INSERT)
                begin
                    if (st_rdata != SLOT_OCCUPIED)
                    begin
                        st_we      = 1'b1;
                        kv_we      = 1'b1;
                        count_next = count_reg + CW'(1);
                        ok_next    = 1'b1;
                        state_next = S_OUT;
                    end
                end
                else if (st_rdata == SLOT_EMPTY)
                begin
                    state_next = S_OUT;
                end
                else if (st_rdata == SLOT_OCCUPIED && kv_rdata[31:0] == key_reg)
                begin
                    ok_next    = 1'b1;
                    state_next = S_OUT;
                    if (op_reg == OP_DELETE)
                    begin
                        st_we    = 1'b1;
                        st_wdata = SLOT_DELETED;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - CW'(1);
                        end
                    end
                    else
                    begin
                        found_next = kv_rdata[63:32];
                    end
                end
                if (state_next == S_RD && last_probe)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = '0;
                    mdata_next[RES_SUCCESS] = ok_reg;
                    mdata_next[RES_FOUND_LO +: VAL_W] = found_reg;
                    mdata_next[RES_FULL]  = (32'(count_reg) == 32'(size));
                    mdata_next[RES_EMPTY] = (count_reg == '0);
                    mdata_next[RES_OCC_LO +: SIZE_W] = SIZE_W'(count_reg);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            count_reg  <= '0;
            mvalid_reg <= 1'b0;
            mode_reg   <= MODE_LINEAR;
            c1_reg     <= '0;
            c2_reg     <= '0;
            tsize_reg  <= 11'd1024;
            cnt_reg    <= '0;
            sel_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            count_reg  <= count_next;
            mvalid_reg <= mvalid_next;
            cnt_reg    <= cnt_next;
            sel_reg    <= sel_next;
            if (cfg_valid)
            begin
                case (cfg_addr)
                    CFG_PROBE_MODE: mode_reg  <= cfg_data[MODE_W-1:0];
                    CFG_QUAD_C1:    c1_reg    <= cfg_data[COEF_W-1:0];
                    CFG_QUAD_C2:    c2_reg    <= cfg_data[COEF_W-1:0];
                    CFG_TABLE_SIZE: tsize_reg <= cfg_data;
                    default:        tsize_reg <= tsize_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        val_reg   <= val_next;
        step_reg  <= step_next;
        div_reg   <= div_next;
        rem_reg   <= rem_next;
        idx_reg   <= idx_next;
        delta_reg <= delta_next;
        dd_reg    <= dd_next;
        pcnt_reg  <= pcnt_next;
        ok_reg    <= ok_next;
        found_reg <= found_next;
        mdata_reg <= mdata_next;
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = mdata_reg;
    assign cfg_ready = 1'b1;

endmodule

>>> rtl/core/oaht_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the hash table, bound to the top level.
// Depends on oaht_pkg and open_addressing_hash_table.
module oaht_checker
    import oaht_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [RES_W-1:0] m_tdata
);

    // A request keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a request was in progress");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result transaction changed");

    a_empty_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[RES_EMPTY] |-> m_tdata[RES_OCC_LO +: SIZE_W] == '0)
        else $error("empty flag set with nonzero occupancy");

    a_value_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[RES_FOUND_LO +: VAL_W] != '0 |-> m_tdata[RES_SUCCESS])
        else $error("found value reported without success");

endmodule

bind open_addressing_hash_table oaht_checker u_oaht_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
